// File: hw/rtl/pdq_pkg.sv
// Shared constants and field layout of the per-channel affine dequantizer.
package pdq_pkg;

    // Table size used when the top level is not told otherwise.
    localparam int DEFAULT_MAX_CHANNELS = 1024;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER_STRIDE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZP_MODE       = 2'd2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_COUNT_W = 11;
    localparam int CFG_MODE_W  = 2;

    // Zero-point modes.
    localparam logic [CFG_MODE_W-1:0] ZP_ABSENT      = 2'd0;
    localparam logic [CFG_MODE_W-1:0] ZP_SHARED      = 2'd1;
    localparam logic [CFG_MODE_W-1:0] ZP_PER_CHANNEL = 2'd2;

    // Item kinds carried in the input tuser.
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_TABLE = 1'b1;

    // Input word layout.
    localparam int SAMPLE_W    = 32;
    localparam int ENTRY_W     = 10;
    localparam int SCALE_W     = 32;
    localparam int ZP_W        = 32;
    localparam int SAMPLE_LSB  = 0;
    localparam int ENTRY_LSB   = SAMPLE_LSB + SAMPLE_W;
    localparam int SCALE_LSB   = ENTRY_LSB + ENTRY_W;
    localparam int ZP_LSB      = SCALE_LSB + SCALE_W;
    localparam int S_FIELDS_W  = ZP_LSB + ZP_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int S_FUNC_BIT  = 0;
    localparam int S_FIRST_BIT = 1;

    // Output word layout.
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    // Arithmetic widths.
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + SCALE_W;

endpackage

// File: hw/rtl/pdq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/per_channel_affine_dequantizer.sv
// Per-channel affine dequantizer: (x - zp) * scale, per-channel tables in RAM.
// A data word passes through stages A, B and C into the output register on m_tdata.
// Throughput: one word per cycle unless the output stalls, set by the single read port
// of each table RAM, which serves one data word per cycle; table writes give no result.
// Reset (aresetn low, synchronous) clears the configuration registers to their defaults,
// the element and channel counters and all pipeline valid bits. The scale and zero-point
// tables are not cleared: an entry must be written before it is used.
module per_channel_affine_dequantizer #(
    parameter int MAX_CHANNELS = pdq_pkg::DEFAULT_MAX_CHANNELS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [pdq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pdq_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0: sample[31:0], entry_index[41:32], scale_word[73:42],
    // zp_word[105:74], zero padding[111:106].
    input  logic [pdq_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser from bit 0: func[0], first_of_tensor[1].
    input  logic [pdq_pkg::S_TUSER_W-1:0]    s_tuser,

    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata from bit 0: dequantized[63:0], signed Q40.24.
    output logic [pdq_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser from bit 0: saturated[0].
    output logic [pdq_pkg::M_TUSER_W-1:0]    m_tuser
);

    import pdq_pkg::*;

    // Table address width and the width used to compare channel counts.
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]  inner_stride_reg;
    logic [CFG_COUNT_W-1:0] channel_count_reg;
    logic [CFG_MODE_W-1:0]  zp_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_stride_reg  <= CFG_DATA_W'(1);
            channel_count_reg <= CFG_COUNT_W'(1);
            zp_mode_reg       <= ZP_ABSENT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_INNER_STRIDE:  inner_stride_reg  <= cfg_wr_data;
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wr_data[CFG_COUNT_W-1:0];
                CFG_ZP_MODE:       zp_mode_reg       <= cfg_wr_data[CFG_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input field unpacking.
    logic                       in_func;
    logic                       in_first;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [ENTRY_W-1:0]         in_entry;
    logic [SCALE_W-1:0]         in_scale;
    logic [ZP_W-1:0]            in_zp;

    assign in_func   = s_tuser[S_FUNC_BIT];
    assign in_first  = s_tuser[S_FIRST_BIT];
    assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];
    assign in_entry  = s_tdata[ENTRY_LSB +: ENTRY_W];
    assign in_scale  = s_tdata[SCALE_LSB +: SCALE_W];
    assign in_zp     = s_tdata[ZP_LSB +: ZP_W];

    // Pipeline registers. Stage A holds the data word while the table RAMs
    // return its entries, stage B holds the difference, stage C the product.
    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    logic                       a_use_zp_reg;
    logic                       b_valid_reg;
    logic signed [DIFF_W-1:0]   b_diff_reg;
    logic signed [SCALE_W-1:0]  b_scale_reg;
    logic                       c_valid_reg;
    logic signed [PROD_W-1:0]   c_prod_reg;
    logic                       m_valid_reg;
    logic [M_TDATA_W-1:0]       m_data_reg;
    logic                       m_sat_reg;

    // Each stage may load when it is empty or when its word moves on. A stalled
    // output therefore still lets words fill the bubbles behind it.
    logic out_free, c_free, b_free, a_free;
    logic accept, data_acc, table_acc;

    assign out_free  = !m_valid_reg || m_tready;
    assign c_free    = !c_valid_reg || out_free;
    assign b_free    = !b_valid_reg || c_free;
    assign a_free    = !a_valid_reg || b_free;
    assign s_tready  = a_free;
    assign accept    = s_tvalid && s_tready;
    assign data_acc  = accept && (in_func == FUNC_DATA);
    assign table_acc = accept && (in_func == FUNC_TABLE);

    // Element and channel counters.
    logic [CFG_DATA_W-1:0] step_pos_reg, step_pos_next;
    logic [AW-1:0]         channel_pos_reg, channel_pos_next;
    logic [CFG_DATA_W-1:0] stride_eff, step_cur, step_inc;
    logic [CMP_W-1:0]      count_ext, count_eff, chan_cur, chan_eff, chan_inc, chan_wrap;
    logic [AW-1:0]         rd_channel;

    always_comb begin
        stride_eff = (inner_stride_reg == '0) ? CFG_DATA_W'(1) : inner_stride_reg;
        count_ext  = CMP_W'(channel_count_reg);
        if (count_ext == '0) begin
            count_eff = CMP_W'(1);
        end else if (count_ext > CMP_W'(MAX_CHANNELS)) begin
            count_eff = CMP_W'(MAX_CHANNELS);
        end else begin
            count_eff = count_ext;
        end

        // A first-of-tensor word starts both counters over; a channel index left
        // out of range by a register change wraps to zero before use.
        step_cur   = in_first ? '0 : step_pos_reg;
        chan_cur   = in_first ? '0 : CMP_W'(channel_pos_reg);
        chan_eff   = (chan_cur >= count_eff) ? '0 : chan_cur;
        rd_channel = chan_eff[AW-1:0];

        step_inc  = step_cur + CFG_DATA_W'(1);
        chan_inc  = chan_eff + CMP_W'(1);
        chan_wrap = (chan_inc >= count_eff) ? '0 : chan_inc;

        step_pos_next    = step_pos_reg;
        channel_pos_next = channel_pos_reg;
        if (data_acc) begin
            if (step_inc >= stride_eff) begin
                step_pos_next    = '0;
                channel_pos_next = chan_wrap[AW-1:0];
            end else begin
                step_pos_next    = step_inc;
                channel_pos_next = rd_channel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_pos_reg    <= '0;
            channel_pos_reg <= '0;
        end else begin
            step_pos_reg    <= step_pos_next;
            channel_pos_reg <= channel_pos_next;
        end
    end

    // Table access. A write and a read of the tables both happen at the edge that
    // accepts their word, so words reach the RAMs strictly in order and a read
    // always sees every earlier write.
    logic [CFG_DATA_W-1:0] entry_ext;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         zp_rd_addr;
    logic [SCALE_W-1:0]    scale_rd;
    logic [ZP_W-1:0]       zp_rd;

    assign entry_ext  = CFG_DATA_W'(in_entry);
    assign wr_en      = table_acc && (entry_ext < CFG_DATA_W'(MAX_CHANNELS));
    assign wr_addr    = entry_ext[AW-1:0];
    assign zp_rd_addr = (zp_mode_reg == ZP_SHARED) ? '0 : rd_channel;

    pdq_ram #(
        .WIDTH (SCALE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_scale_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_scale),
        .rd_en   (data_acc),
        .rd_addr (rd_channel),
        .rd_data (scale_rd)
    );

    pdq_ram #(
        .WIDTH (ZP_W),
        .DEPTH (MAX_CHANNELS)
    ) u_zp_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_zp),
        .rd_en   (data_acc),
        .rd_addr (zp_rd_addr),
        .rd_data (zp_rd)
    );

    // Arithmetic. The difference needs one bit more than the sample; the product
    // of a 33-bit difference and a 32-bit scale fits in 65 bits and is then
    // clamped to the signed 64-bit range.
    logic signed [ZP_W-1:0]   zp_used;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_ovf;
    logic [M_TDATA_W-1:0]     sat_value;

    always_comb begin
        zp_used   = a_use_zp_reg ? $signed(zp_rd) : '0;
        diff_next = DIFF_W'(a_sample_reg) - DIFF_W'(zp_used);
        prod_next = PROD_W'(b_diff_reg) * PROD_W'(b_scale_reg);
        prod_ovf  = c_prod_reg[PROD_W-1] != c_prod_reg[PROD_W-2];
        sat_value = c_prod_reg[PROD_W-1] ? {1'b1, {(M_TDATA_W-1){1'b0}}}
                                         : {1'b0, {(M_TDATA_W-1){1'b1}}};
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= data_acc;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free) begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (data_acc) begin
            a_sample_reg <= in_sample;
            a_use_zp_reg <= (zp_mode_reg == ZP_SHARED) || (zp_mode_reg == ZP_PER_CHANNEL);
        end
        if (b_free && a_valid_reg) begin
            b_diff_reg  <= diff_next;
            b_scale_reg <= $signed(scale_rd);
        end
        if (c_free && b_valid_reg) begin
            c_prod_reg <= prod_next;
        end
        if (out_free && c_valid_reg) begin
            m_data_reg <= prod_ovf ? sat_value : c_prod_reg[M_TDATA_W-1:0];
            m_sat_reg  <= prod_ovf;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule
